// ===== src/guest_memory_bus_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the guest memory bus decoder
// Implication checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GUEST_MEMORY_BUS_DECODER_TOP_ASSERT_SVH
`define GUEST_MEMORY_BUS_DECODER_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define GMBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmbd: same-cycle check failed");
// next-cycle implication
`define GMBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmbd: next-cycle check failed");
`else
`define GMBD_ASSERT_IMP(lbl, ante, cons)
`define GMBD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/gmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gmbd_pkg
// Codes, address windows and the decode record shared by the bus decoder.
// ----------------------------------------------------------------------------
package gmbd_pkg;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;
  localparam logic [1:0] SIZE_RSVD = 2'd3;

  localparam logic [1:0] FAULT_NONE       = 2'd0;
  localparam logic [1:0] FAULT_UNMAPPED   = 2'd1;
  localparam logic [1:0] FAULT_MISALIGNED = 2'd2;

  // hardware windows, upper bound exclusive
  localparam logic [31:0] CHIP_LO = 32'h00DF_F000;
  localparam logic [31:0] CHIP_HI = 32'h00E0_0000;
  localparam logic [31:0] CIAB_LO = 32'h00BF_D000;
  localparam logic [31:0] CIAB_HI = 32'h00BF_E000;
  localparam logic [31:0] CIAA_LO = 32'h00BF_E000;
  localparam logic [31:0] CIAA_HI = 32'h00BF_F000;

  typedef struct packed {
    logic [1:0] fault;     // fault code, FAULT_NONE if clean
    logic       hw_sel;    // forward to hardware port
    logic       ram_go;    // clean RAM access
    logic [1:0] last_idx;  // bytes in access minus one
  } decode_t;

endpackage

// ===== src/gmbd_decode.sv =====
// ----------------------------------------------------------------------------
// gmbd_decode
// Classifies one access: fault, hardware window or in-range RAM access.
// ----------------------------------------------------------------------------
module gmbd_decode import gmbd_pkg::*; #(
  parameter int unsigned MEM_BYTES = 524288
) (
  input  logic        kind,
  input  logic [1:0]  size,
  input  logic [31:0] address,
  output decode_t     dec
);

  logic       odd;
  logic       win;
  logic       over;
  logic [2:0] nbytes;

  assign odd = (size != SIZE_BYTE) && address[0];
  assign win = (address >= CHIP_LO && address < CHIP_HI) ||
               (address >= CIAB_LO && address < CIAB_HI) ||
               (address >= CIAA_LO && address < CIAA_HI);

  always_comb begin
    unique case (size)
      SIZE_BYTE: nbytes = 3'd1;
      SIZE_WORD: nbytes = 3'd2;
      default:   nbytes = 3'd4;
    endcase
  end

  assign over = ({1'b0, address} + 33'(nbytes)) > 33'(MEM_BYTES);

  always_comb begin
    dec.fault    = FAULT_NONE;
    dec.hw_sel   = 1'b0;
    dec.ram_go   = 1'b0;
    dec.last_idx = 2'(nbytes - 3'd1);
    priority if (size == SIZE_RSVD) begin
      dec.fault = FAULT_UNMAPPED;
    end else if (odd) begin
      dec.fault = (kind == KIND_WRITE) ? FAULT_MISALIGNED : FAULT_UNMAPPED;
    end else if (win) begin
      dec.hw_sel = 1'b1;
    end else if (over) begin
      dec.fault = FAULT_UNMAPPED;
    end else begin
      dec.ram_go = 1'b1;
    end
  end

endmodule

// ===== src/guest_memory_bus_decoder_top.sv =====
// ----------------------------------------------------------------------------
// guest_memory_bus_decoder_top
// Bus access decoder with a byte-wide big-endian RAM, one byte per cycle.
// ----------------------------------------------------------------------------
// From accept, every access is decoded in ST_DEC, where faults and hardware
// accesses finish; a RAM access steps through ST_ACC once per byte (n = 1, 2
// or 4 bytes), and a RAM read then passes ST_DRAIN. A new word is taken the
// cycle the result shows; the single byte port of the RAM sets the per-byte cost.
// Synchronous active-low reset clears control; RAM contents stay undefined.
// Results cannot be stalled by the receiver.
module guest_memory_bus_decoder_top import gmbd_pkg::*; #(
  parameter int unsigned MEM_BYTES = 524288
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [1:0]  in_size,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_fault,
  output logic        out_hw_select,
  output logic        out_hw_is_write,
  output logic [1:0]  out_hw_size,
  output logic [31:0] out_hw_address,
  output logic [31:0] out_hw_write_data
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DEC   = 2'd1;
  localparam logic [1:0] ST_ACC   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  last_r, last_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [31:0] acc_r, acc_nxt;

  logic        kind_r;
  logic [1:0]  size_r;
  logic [31:0] addr_r;
  logic [31:0] wdata_r;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_read_data_r, out_read_data_nxt;
  logic [1:0]  out_fault_r, out_fault_nxt;
  logic        out_hw_select_r, out_hw_select_nxt;
  logic        out_hw_is_write_r, out_hw_is_write_nxt;
  logic [1:0]  out_hw_size_r, out_hw_size_nxt;
  logic [31:0] out_hw_address_r, out_hw_address_nxt;
  logic [31:0] out_hw_write_data_r, out_hw_write_data_nxt;

  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    mem_rdata_r;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [1:0]    byte_sel;
  logic [31:0]   hw_wmask;
  logic          accept;

  decode_t dec;

  gmbd_decode #(
    .MEM_BYTES (MEM_BYTES)
  ) u_decode (
    .kind    (kind_r),
    .size    (size_r),
    .address (addr_r),
    .dec     (dec)
  );

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // big-endian: byte idx of the access is bits of the value at (last - idx)
  assign byte_sel  = last_r - idx_r;
  assign mem_addr  = addr_r[AW-1:0] + AW'(idx_r);
  assign mem_wdata = wdata_r[{byte_sel, 3'b000} +: 8];
  assign mem_we    = (state_r == ST_ACC) && (kind_r == KIND_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  always_comb begin
    unique case (size_r)
      SIZE_BYTE: hw_wmask = {24'd0, wdata_r[7:0]};
      SIZE_WORD: hw_wmask = {16'd0, wdata_r[15:0]};
      default:   hw_wmask = wdata_r;
    endcase
  end

  always_comb begin
    state_nxt             = state_r;
    idx_nxt               = idx_r;
    last_nxt              = last_r;
    rd_pend_nxt           = 1'b0;
    acc_nxt               = acc_r;
    out_valid_nxt         = 1'b0;
    out_read_data_nxt     = out_read_data_r;
    out_fault_nxt         = out_fault_r;
    out_hw_select_nxt     = out_hw_select_r;
    out_hw_is_write_nxt   = out_hw_is_write_r;
    out_hw_size_nxt       = out_hw_size_r;
    out_hw_address_nxt    = out_hw_address_r;
    out_hw_write_data_nxt = out_hw_write_data_r;

    if (rd_pend_r) begin
      acc_nxt = {acc_r[23:0], mem_rdata_r};
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        idx_nxt  = 2'd0;
        last_nxt = dec.last_idx;
        acc_nxt  = 32'd0;
        if (dec.ram_go) begin
          state_nxt = ST_ACC;
        end else begin
          state_nxt             = ST_IDLE;
          out_valid_nxt         = 1'b1;
          out_read_data_nxt     = 32'd0;
          out_fault_nxt         = dec.fault;
          out_hw_select_nxt     = dec.hw_sel;
          out_hw_is_write_nxt   = dec.hw_sel && (kind_r == KIND_WRITE);
          out_hw_size_nxt       = dec.hw_sel ? size_r : SIZE_BYTE;
          out_hw_address_nxt    = dec.hw_sel ? addr_r : 32'd0;
          out_hw_write_data_nxt = (dec.hw_sel && kind_r == KIND_WRITE) ? hw_wmask : 32'd0;
        end
      end
      ST_ACC: begin
        rd_pend_nxt = (kind_r == KIND_READ);
        idx_nxt     = idx_r + 2'd1;
        if (idx_r == last_r) begin
          if (kind_r == KIND_WRITE) begin
            state_nxt             = ST_IDLE;
            out_valid_nxt         = 1'b1;
            out_read_data_nxt     = 32'd0;
            out_fault_nxt         = FAULT_NONE;
            out_hw_select_nxt     = 1'b0;
            out_hw_is_write_nxt   = 1'b0;
            out_hw_size_nxt       = SIZE_BYTE;
            out_hw_address_nxt    = 32'd0;
            out_hw_write_data_nxt = 32'd0;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // last byte lands this cycle
        state_nxt             = ST_IDLE;
        out_valid_nxt         = 1'b1;
        out_read_data_nxt     = {acc_r[23:0], mem_rdata_r};
        out_fault_nxt         = FAULT_NONE;
        out_hw_select_nxt     = 1'b0;
        out_hw_is_write_nxt   = 1'b0;
        out_hw_size_nxt       = SIZE_BYTE;
        out_hw_address_nxt    = 32'd0;
        out_hw_write_data_nxt = 32'd0;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      size_r  <= in_size;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
    end
    idx_r               <= idx_nxt;
    last_r              <= last_nxt;
    acc_r               <= acc_nxt;
    out_read_data_r     <= out_read_data_nxt;
    out_fault_r         <= out_fault_nxt;
    out_hw_select_r     <= out_hw_select_nxt;
    out_hw_is_write_r   <= out_hw_is_write_nxt;
    out_hw_size_r       <= out_hw_size_nxt;
    out_hw_address_r    <= out_hw_address_nxt;
    out_hw_write_data_r <= out_hw_write_data_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_read_data_r;
  assign out_fault         = out_fault_r;
  assign out_hw_select     = out_hw_select_r;
  assign out_hw_is_write   = out_hw_is_write_r;
  assign out_hw_size       = out_hw_size_r;
  assign out_hw_address    = out_hw_address_r;
  assign out_hw_write_data = out_hw_write_data_r;

`include "guest_memory_bus_decoder_top_assert.svh"

  `GMBD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `GMBD_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `GMBD_ASSERT_IMP(a_rdata_clean, out_valid && out_read_data != 32'd0, out_fault == FAULT_NONE && !out_hw_select)
  `GMBD_ASSERT_IMP(a_hw_nofault, out_valid && out_hw_select, out_fault == FAULT_NONE)

endmodule
